// ===== design/calclk_pkg.sv =====
// Shared types, constants and helper functions for the calendar clock counter.
// Used by the top level and by its checker; depends on nothing else.
package calclk_pkg;

  localparam logic [15:0] TPS_RESET   = 16'd1000;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [4:0]  DAY_LAST    = 5'd31;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [5:0]  SECOND_LAST = 6'd59;

  // Register map: word index of each configuration register.
  localparam logic [0:0]  REG_TPS     = 1'b0;
  localparam int unsigned PADDR_W     = 3;

  // Multiplicative inverse of 25 modulo 2**14. A 14-bit year is a multiple
  // of 25 exactly when year * inverse (mod 2**14) is at most 16383 / 25.
  localparam logic [13:0] INV25       = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT = 14'd655;

  // Opcodes of the func field.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } in_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        set_rejected;
    logic        second_advanced;
  } out_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  localparam cal_t CAL_RESET = '{year: 14'd0, month: 4'd1, day: 5'd1,
                                 hour: 5'd0, minute: 6'd0, second: 6'd0};

  // Gregorian rule: leap when divisible by 4 and not by 100, or by 400.
  // Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIMIT);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                       n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
      default:                    n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== design/calendar_clock_counter.sv =====
// Calendar clock counter top level: input register, calendar update logic and
// result register, plus an APB register for ticks per second. Uses calclk_pkg.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle; the input register and the result register
// each take a new item whenever the stage after them is free or emptying.
// The figure is set by the single calendar update between the two registers.
// Reset (rst, synchronous): calendar to year 0, January 1, 00:00:00, prescaler
// to 0, ticks per second to 1000, both stages empty.
module calendar_clock_counter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  calclk_pkg::in_item_t                 in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output calclk_pkg::out_item_t                out_item,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [calclk_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import calclk_pkg::*;

  logic        tps;
  logic [15:0] ticks_per_second;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  cal_t        cal;
  cal_t        cal_next;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_free;
  logic        proc;
  out_item_t   result;

  logic        reg_hit;
  logic        set_ok;
  logic        advance;
  logic [16:0] tick_inc;
  logic [15:0] limit;
  logic [4:0]  mlen;
  cal_t        cal_adv;

  assign pready   = 1'b1;
  assign reg_hit  = (paddr[PADDR_W-1:2] == REG_TPS);
  assign tps      = psel && penable && pwrite && reg_hit;
  assign prdata   = reg_hit ? {16'd0, ticks_per_second} : 32'd0;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !in_valid_q || out_free;
  assign proc     = in_valid_q && out_free;

  // One-second advance with carries through the whole calendar.
  always_comb begin
    mlen    = month_len(cal.month, is_leap(cal.year));
    cal_adv = cal;
    if (cal.second < SECOND_LAST) begin
      cal_adv.second = cal.second + 6'd1;
    end else begin
      cal_adv.second = 6'd0;
      if (cal.minute < MINUTE_LAST) begin
        cal_adv.minute = cal.minute + 6'd1;
      end else begin
        cal_adv.minute = 6'd0;
        if (cal.hour < HOUR_LAST) begin
          cal_adv.hour = cal.hour + 5'd1;
        end else begin
          cal_adv.hour = 5'd0;
          if ({1'b0, cal.day} + 6'd1 <= {1'b0, mlen}) begin
            cal_adv.day = cal.day + 5'd1;
          end else begin
            cal_adv.day = DAY_FIRST;
            if (cal.month < MONTH_LAST) begin
              cal_adv.month = cal.month + 4'd1;
            end else begin
              cal_adv.month = MONTH_FIRST;
              cal_adv.year  = (cal.year >= YEAR_MAX) ? 14'd0 : cal.year + 14'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    limit    = (ticks_per_second == 16'd0) ? 16'd1 : ticks_per_second;
    tick_inc = {1'b0, tick_count} + 17'd1;
    set_ok   = (in_q.set_year <= YEAR_MAX) &&
               (in_q.set_month inside {[MONTH_FIRST:MONTH_LAST]}) &&
               (in_q.set_day inside {[DAY_FIRST:DAY_LAST]}) &&
               (in_q.set_hour <= HOUR_LAST) &&
               (in_q.set_minute <= MINUTE_LAST) &&
               (in_q.set_second <= SECOND_LAST);
    advance         = 1'b0;
    cal_next        = cal;
    tick_count_next = tick_count;
    case (in_q.func)
      FUNC_SET: begin
        if (set_ok) begin
          cal_next = '{year: in_q.set_year, month: in_q.set_month,
                       day: in_q.set_day, hour: in_q.set_hour,
                       minute: in_q.set_minute, second: in_q.set_second};
          tick_count_next = 16'd0;
        end
      end
      default: begin
        if (tick_inc >= {1'b0, limit}) begin
          advance         = 1'b1;
          tick_count_next = 16'd0;
          cal_next        = cal_adv;
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end
    endcase
    result.year            = cal_next.year;
    result.month           = cal_next.month;
    result.day             = cal_next.day;
    result.hour            = cal_next.hour;
    result.minute          = cal_next.minute;
    result.second          = cal_next.second;
    result.set_rejected    = (in_q.func == FUNC_SET) && !set_ok;
    result.second_advanced = advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      tick_count       <= 16'd0;
      cal              <= CAL_RESET;
      in_valid_q       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (tps) begin
        ticks_per_second <= pwdata[15:0];
      end
      if (in_valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        tick_count <= tick_count_next;
        cal        <= cal_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
    if (proc) begin
      out_item <= result;
    end
  end

endmodule

// ===== design/calclk_checker.sv =====
// Port-level checker for the calendar clock counter, bound to the top level.
// Uses calclk_pkg for the item types and field limits.
module calclk_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input calclk_pkg::out_item_t out_item
);
  import calclk_pkg::*;

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // The calendar fields shown stay in range; the day is checked only against its lower bound.
  a_cal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.month >= MONTH_FIRST) && (out_item.month <= MONTH_LAST) &&
                  (out_item.day >= DAY_FIRST) && (out_item.hour <= HOUR_LAST) &&
                  (out_item.minute <= MINUTE_LAST) && (out_item.second <= SECOND_LAST) &&
                  (out_item.year <= YEAR_MAX))
    else $error("calendar field out of range");

  // A tick never rejects and a set never advances.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.set_rejected && out_item.second_advanced))
    else $error("both result flags set");

endmodule

bind calendar_clock_counter calclk_checker u_calclk_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
